/* src/battery_discharge_test_controller_defines.svh */
// ============================================================================
// Battery discharge test controller - assertion macros
// Concurrent assertion wrappers clocked on clock and disabled in reset.
// ============================================================================
`ifndef BATTERY_DISCHARGE_TEST_CONTROLLER_DEFINES_SVH
`define BATTERY_DISCHARGE_TEST_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
`define BDTC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define BDTC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define BDTC_ASSERT(label, prop, msg)
`define BDTC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* src/bdtc_pkg.sv */
// ============================================================================
// Battery discharge test controller - package
// Shared constants, register indexes and stage payload types.
// ============================================================================
package bdtc_pkg;

   localparam int TICKS_PER_SECOND = 20;
   localparam int TICK_W           = 10;
   localparam logic [TICK_W:0] TICK_LIMIT = (TICK_W + 1)'(TICKS_PER_SECOND);

   localparam int VADC_W  = 10;
   localparam int IADC_W  = 10;
   localparam int VOLT_W  = 13;
   localparam int CURR_W  = 14;
   localparam int OFFS_W  = 10;
   localparam int CHG_W   = 13;
   localparam int CAP_W   = 40;
   localparam int SECS_W  = 32;
   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int SEC_W   = 6;

   localparam logic [CAP_W-1:0] CAP_MAX = {CAP_W{1'b1}};

   localparam logic [VOLT_W-1:0] LOW_VOLTAGE_RESET    = 13'd3000;
   localparam logic [OFFS_W-1:0] VOLTAGE_OFFSET_RESET = 10'd200;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_VOLTAGE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VOLTAGE_OFFSET = 2'd1;

   typedef struct packed {
      logic              vld;
      logic [VOLT_W-1:0] voltage_mv;
      logic [CURR_W-1:0] current_ma;
      logic              start_level;
      logic              clear_level;
   } conv_type;

   typedef struct packed {
      logic              vld;
      logic [VOLT_W-1:0] voltage_mv;
      logic [CURR_W-1:0] current_ma;
      logic [CHG_W-1:0]  charge_uah;
      logic              start_level;
      logic              clear_level;
   } charge_type;

   typedef struct packed {
      logic              running;
      logic [HOUR_W-1:0] hours;
      logic [MIN_W-1:0]  minutes;
      logic [SEC_W-1:0]  seconds;
      logic [VOLT_W-1:0] voltage_mv;
      logic [CURR_W-1:0] current_ma;
      logic [CAP_W-1:0]  capacity_uah;
      logic              battery_empty;
      logic              display_refresh;
   } result_type;

endpackage

/* src/bdtc_req_if.sv */
// ============================================================================
// Battery discharge test controller - request channel
// One scheduler tick: ADC readings and active-low button levels.
// ============================================================================
interface bdtc_req_if;
   logic                         valid;
   logic                         ready;
   logic [bdtc_pkg::VADC_W-1:0]  voltage_adc;
   logic [bdtc_pkg::IADC_W-1:0]  current_adc;
   logic                         start_level;
   logic                         clear_level;

   modport source (output valid, output voltage_adc, output current_adc,
                   output start_level, output clear_level, input ready);
   modport sink   (input valid, input voltage_adc, input current_adc,
                   input start_level, input clear_level, output ready);
endinterface

/* src/bdtc_rsp_if.sv */
// ============================================================================
// Battery discharge test controller - response channel
// Test status, elapsed time, measurements and capacity after one tick.
// ============================================================================
interface bdtc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         running;
   logic [bdtc_pkg::HOUR_W-1:0]  hours;
   logic [bdtc_pkg::MIN_W-1:0]   minutes;
   logic [bdtc_pkg::SEC_W-1:0]   seconds;
   logic [bdtc_pkg::VOLT_W-1:0]  voltage_mv;
   logic [bdtc_pkg::CURR_W-1:0]  current_ma;
   logic [bdtc_pkg::CAP_W-1:0]   capacity_uah;
   logic                         battery_empty;
   logic                         display_refresh;

   modport source (output valid, output running, output hours, output minutes,
                   output seconds, output voltage_mv, output current_ma,
                   output capacity_uah, output battery_empty,
                   output display_refresh, input ready);
   modport sink   (input valid, input running, input hours, input minutes,
                   input seconds, input voltage_mv, input current_ma,
                   input capacity_uah, input battery_empty,
                   input display_refresh, output ready);
endinterface

/* src/bdtc_csr_if.sv */
// ============================================================================
// Battery discharge test controller - configuration write channel
// Register index and write data with a valid/ready handshake.
// ============================================================================
interface bdtc_csr_if;
   logic                              valid;
   logic                              ready;
   logic [bdtc_pkg::CSR_INDEX_W-1:0]  index;
   logic [bdtc_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/bdtc_convert.sv */
// ============================================================================
// Battery discharge test controller - ADC conversion stage
// Scale ADC readings to mV and mA and register them.
// ============================================================================
module bdtc_convert (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic [bdtc_pkg::VADC_W-1:0]   voltage_adc,
   input  logic [bdtc_pkg::IADC_W-1:0]   current_adc,
   input  logic                          start_level,
   input  logic                          clear_level,
   input  logic [bdtc_pkg::OFFS_W-1:0]   voltage_offset_mv,
   output bdtc_pkg::conv_type            conv
);

   localparam logic [bdtc_pkg::VOLT_W-1:0] OFFSET_KNEE = 13'd600;

   // floor(x / 1023): estimate from x/1024 series, then one remainder fix
   function automatic logic [13:0] div1023(input logic [23:0] x);
      logic [24:0] y;
      logic [14:0] q;
      logic [24:0] qm;
      logic [24:0] r;
      y  = 25'(x) + 25'(x >> 10) + 25'(x >> 20);
      q  = y[24:10];
      qm = {q, 10'b0} - 25'(q);
      r  = 25'(x) - qm;
      if (r >= 25'd1023) begin
         q = q + 15'd1;
      end
      return q[13:0];
   endfunction

   bdtc_pkg::conv_type            conv_in;
   bdtc_pkg::conv_type            conv_ff;
   logic [bdtc_pkg::VOLT_W-1:0]   volt_raw;
   logic [bdtc_pkg::VOLT_W-1:0]   offset_ext;

   always_comb begin
      volt_raw   = bdtc_pkg::VOLT_W'(div1023(24'(voltage_adc) * 24'd5000));
      offset_ext = bdtc_pkg::VOLT_W'(voltage_offset_mv);
      conv_in.vld         = in_valid;
      conv_in.start_level = start_level;
      conv_in.clear_level = clear_level;
      conv_in.current_ma  = div1023(24'(current_adc) * 24'd10000);
      conv_in.voltage_mv  = volt_raw;
      // remove wiring drop above the knee, floor at zero
      if (volt_raw > OFFSET_KNEE) begin
         conv_in.voltage_mv = (volt_raw > offset_ext) ? volt_raw - offset_ext : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conv_ff.vld <= 1'b0;
      end else if (advance) begin
         conv_ff <= conv_in;
      end
   end

   assign conv = conv_ff;

endmodule

/* src/bdtc_charge.sv */
// ============================================================================
// Battery discharge test controller - charge stage
// Charge of one second at the measured current, in uAh.
// ============================================================================
module bdtc_charge (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  bdtc_pkg::conv_type   conv,
   output bdtc_pkg::charge_type chg
);

   // 1000/3600 = 5/18; floor(x/18) through a 2^20 reciprocal plus one fix
   localparam logic [15:0] RECIP18 = 16'd58254;

   logic [16:0]                  scaled;
   logic [32:0]                  product;
   logic [bdtc_pkg::CHG_W-1:0]   quot;
   logic [16:0]                  remain;
   bdtc_pkg::charge_type         chg_in;
   bdtc_pkg::charge_type         chg_ff;

   always_comb begin
      scaled  = 17'(conv.current_ma) * 17'd5;
      product = 33'(scaled) * 33'(RECIP18);
      quot    = product[32:20];
      remain  = scaled - 17'(quot) * 17'd18;
      if (remain >= 17'd18) begin
         quot = quot + 13'd1;
      end
      chg_in.vld         = conv.vld;
      chg_in.voltage_mv  = conv.voltage_mv;
      chg_in.current_ma  = conv.current_ma;
      chg_in.charge_uah  = quot;
      chg_in.start_level = conv.start_level;
      chg_in.clear_level = conv.clear_level;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chg_ff.vld <= 1'b0;
      end else if (advance) begin
         chg_ff <= chg_in;
      end
   end

   assign chg = chg_ff;

endmodule

/* src/bdtc_state.sv */
// ============================================================================
// Battery discharge test controller - test state and result register
// Timer, refresh, capacity, empty detection and buttons, one tick per cycle while advancing.
// ============================================================================
`include "battery_discharge_test_controller_defines.svh"

module bdtc_state (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  bdtc_pkg::charge_type          chg,
   input  logic [bdtc_pkg::VOLT_W-1:0]   low_voltage_mv,
   output logic                          rsp_valid,
   output bdtc_pkg::result_type          result
);

   localparam logic [bdtc_pkg::SEC_W-1:0]  SEC_LAST  = 6'd59;
   localparam logic [bdtc_pkg::MIN_W-1:0]  MIN_LAST  = 6'd59;
   localparam logic [bdtc_pkg::HOUR_W-1:0] HOUR_LAST = 5'd23;

   logic [bdtc_pkg::TICK_W-1:0]  tick_count_ff, tick_count_in;
   logic [bdtc_pkg::SECS_W-1:0]  elapsed_seconds_ff, elapsed_seconds_in;
   logic [bdtc_pkg::SEC_W-1:0]   sec_ff, sec_in;
   logic [bdtc_pkg::MIN_W-1:0]   min_ff, min_in;
   logic [bdtc_pkg::HOUR_W-1:0]  hour_ff, hour_in;
   logic                         refresh_pending_ff, refresh_pending_in;
   logic                         run_flag_ff, run_flag_in;
   logic                         empty_flag_ff, empty_flag_in;
   logic                         last_start_level_ff, last_start_level_in;
   logic [bdtc_pkg::CAP_W-1:0]   capacity_acc_ff, capacity_acc_in;
   logic [bdtc_pkg::VOLT_W-1:0]  voltage_ff, voltage_in;
   logic [bdtc_pkg::CURR_W-1:0]  current_ff, current_in;
   logic                         rsp_valid_ff;
   bdtc_pkg::result_type         result_ff, result_in;

   logic                         update;
   logic                         second_tick;
   logic                         refresh;
   logic                         toggle;
   logic [bdtc_pkg::TICK_W:0]    tick_sum;
   logic [bdtc_pkg::CAP_W:0]     cap_sum;

   assign update = chg.vld && advance;

   always_comb begin
      tick_count_in       = tick_count_ff;
      elapsed_seconds_in  = elapsed_seconds_ff;
      sec_in              = sec_ff;
      min_in              = min_ff;
      hour_in             = hour_ff;
      capacity_acc_in     = capacity_acc_ff;
      voltage_in          = voltage_ff;
      current_in          = current_ff;
      empty_flag_in       = empty_flag_ff;
      run_flag_in         = run_flag_ff;
      second_tick         = 1'b0;
      tick_sum            = {1'b0, tick_count_ff} + 1'b1;
      cap_sum             = {1'b0, capacity_acc_ff} + (bdtc_pkg::CAP_W + 1)'(chg.charge_uah);

      // timer: advance the tick counter and the wall clock while running
      if (run_flag_ff) begin
         tick_count_in = tick_sum[bdtc_pkg::TICK_W-1:0];
         if (tick_sum >= bdtc_pkg::TICK_LIMIT) begin
            tick_count_in      = '0;
            elapsed_seconds_in = elapsed_seconds_ff + 1'b1;
            second_tick        = 1'b1;
            if (sec_ff == SEC_LAST) begin
               sec_in = '0;
               if (min_ff == MIN_LAST) begin
                  min_in  = '0;
                  hour_in = (hour_ff == HOUR_LAST) ? '0 : hour_ff + 1'b1;
               end else begin
                  min_in = min_ff + 1'b1;
               end
            end else begin
               sec_in = sec_ff + 1'b1;
            end
            // seconds counter wraps to zero: clock display restarts too
            if (elapsed_seconds_ff == '1) begin
               sec_in  = '0;
               min_in  = '0;
               hour_in = '0;
            end
         end
      end

      refresh            = refresh_pending_ff || second_tick;
      refresh_pending_in = 1'b0;

      if (refresh) begin
         voltage_in = chg.voltage_mv;
         current_in = chg.current_ma;
         if (second_tick) begin
            capacity_acc_in = cap_sum[bdtc_pkg::CAP_W] ? bdtc_pkg::CAP_MAX
                                                       : cap_sum[bdtc_pkg::CAP_W-1:0];
         end
         if (chg.voltage_mv <= low_voltage_mv) begin
            empty_flag_in = 1'b1;
         end
      end

      // start/stop on falling edge; an empty battery keeps forcing a stop
      toggle = (!chg.start_level && last_start_level_ff) || empty_flag_in;
      if (toggle) begin
         if (!run_flag_ff && !empty_flag_in) begin
            run_flag_in = 1'b1;
         end else begin
            run_flag_in        = 1'b0;
            refresh_pending_in = 1'b1;
         end
      end
      last_start_level_in = chg.start_level;

      if (!chg.clear_level) begin
         run_flag_in        = 1'b0;
         elapsed_seconds_in = '0;
         tick_count_in      = '0;
         sec_in             = '0;
         min_in             = '0;
         hour_in            = '0;
         capacity_acc_in    = '0;
         empty_flag_in      = 1'b0;
         refresh_pending_in = 1'b1;
      end

      result_in.running         = run_flag_in;
      result_in.hours           = hour_in;
      result_in.minutes         = min_in;
      result_in.seconds         = sec_in;
      result_in.voltage_mv      = voltage_in;
      result_in.current_ma      = current_in;
      result_in.capacity_uah    = capacity_acc_in;
      result_in.battery_empty   = empty_flag_in;
      result_in.display_refresh = refresh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff       <= '0;
         elapsed_seconds_ff  <= '0;
         sec_ff              <= '0;
         min_ff              <= '0;
         hour_ff             <= '0;
         refresh_pending_ff  <= 1'b1;
         run_flag_ff         <= 1'b0;
         empty_flag_ff       <= 1'b0;
         last_start_level_ff <= 1'b1;
         capacity_acc_ff     <= '0;
         voltage_ff          <= '0;
         current_ff          <= '0;
      end else if (update) begin
         tick_count_ff       <= tick_count_in;
         elapsed_seconds_ff  <= elapsed_seconds_in;
         sec_ff              <= sec_in;
         min_ff              <= min_in;
         hour_ff             <= hour_in;
         refresh_pending_ff  <= refresh_pending_in;
         run_flag_ff         <= run_flag_in;
         empty_flag_ff       <= empty_flag_in;
         last_start_level_ff <= last_start_level_in;
         capacity_acc_ff     <= capacity_acc_in;
         voltage_ff          <= voltage_in;
         current_ff          <= current_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= chg.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

   `BDTC_ASSERT(a_tick_bound, tick_count_ff < bdtc_pkg::TICK_LIMIT, "tick counter past limit")
   `BDTC_ASSERT(a_clock_bound, sec_ff <= SEC_LAST && min_ff <= MIN_LAST && hour_ff <= HOUR_LAST, "h:m:s out of range")
   `BDTC_ASSERT(a_empty_idle, !(rsp_valid_ff && result_ff.battery_empty && result_ff.running), "running while empty")
   `BDTC_ASSERT_NEXT(a_clear_zeroes, update && !chg.clear_level, !run_flag_ff && elapsed_seconds_ff == '0 && capacity_acc_ff == '0 && !empty_flag_ff && refresh_pending_ff, "clear not applied")
   `BDTC_ASSERT_NEXT(a_cap_monotonic, update && chg.clear_level, capacity_acc_ff >= $past(capacity_acc_ff), "capacity decreased without clear")

endmodule

/* src/battery_discharge_test_controller.sv */
// ============================================================================
// Battery discharge test controller
// Pipeline: a tick transaction accepted at one edge loads the conversion
// register; the charge and state registers then load in turn, each one
// only while the pipeline advances.
// Throughput: one tick per cycle while the response side is not stalled.
// Reset: synchronous, active high; test stopped, time and capacity zero,
// first tick refreshes, thresholds 3000 mV empty and 200 mV offset.
// ============================================================================
module battery_discharge_test_controller (
   input  logic              clock,
   input  logic              reset,
   bdtc_req_if.sink          req_bus,
   bdtc_rsp_if.source        rsp_bus,
   bdtc_csr_if.sink          csr_bus
);

   // Configuration registers
   logic [bdtc_pkg::VOLT_W-1:0]  low_voltage_ff;
   logic [bdtc_pkg::OFFS_W-1:0]  voltage_offset_ff;

   // Pipeline control: move every stage together whenever the result
   // register is empty or being drained this cycle
   logic                         advance;
   logic                         rsp_valid;
   bdtc_pkg::conv_type           conv;
   bdtc_pkg::charge_type         chg;
   bdtc_pkg::result_type         result;

   assign advance       = !rsp_valid || rsp_bus.ready;
   assign req_bus.ready = advance;
   assign csr_bus.ready = 1'b1;

   // Register writes are registered; index codes beyond the list drop
   always_ff @(posedge clock) begin
      if (reset) begin
         low_voltage_ff    <= bdtc_pkg::LOW_VOLTAGE_RESET;
         voltage_offset_ff <= bdtc_pkg::VOLTAGE_OFFSET_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            bdtc_pkg::CSR_LOW_VOLTAGE: begin
               low_voltage_ff <= csr_bus.data[bdtc_pkg::VOLT_W-1:0];
            end
            bdtc_pkg::CSR_VOLTAGE_OFFSET: begin
               voltage_offset_ff <= csr_bus.data[bdtc_pkg::OFFS_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Scale ADC readings to mV / mA
   bdtc_convert u_convert (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .in_valid          (req_bus.valid),
      .voltage_adc       (req_bus.voltage_adc),
      .current_adc       (req_bus.current_adc),
      .start_level       (req_bus.start_level),
      .clear_level       (req_bus.clear_level),
      .voltage_offset_mv (voltage_offset_ff),
      .conv              (conv)
   );

   // Precompute charge of one second at that current
   bdtc_charge u_charge (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .conv    (conv),
      .chg     (chg)
   );

   // Apply timer, refresh, capacity, empty check and buttons
   bdtc_state u_state (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .chg            (chg),
      .low_voltage_mv (low_voltage_ff),
      .rsp_valid      (rsp_valid),
      .result         (result)
   );

   // Drive the response transaction from the result register
   assign rsp_bus.valid           = rsp_valid;
   assign rsp_bus.running         = result.running;
   assign rsp_bus.hours           = result.hours;
   assign rsp_bus.minutes         = result.minutes;
   assign rsp_bus.seconds         = result.seconds;
   assign rsp_bus.voltage_mv      = result.voltage_mv;
   assign rsp_bus.current_ma      = result.current_ma;
   assign rsp_bus.capacity_uah    = result.capacity_uah;
   assign rsp_bus.battery_empty   = result.battery_empty;
   assign rsp_bus.display_refresh = result.display_refresh;

endmodule

/* tb/tb.sv */
// ============================================================================
// Battery discharge test controller - testbench
// Sends scheduler ticks through the request channel, predicts every status
// transaction with an in-bench model of the timer, the ADC scaling, the
// capacity count and the buttons, and checks each response field by field.
// Random gaps on the request side and stalls on the response side.
// ============================================================================
module tb;

   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned MAX_REPORTS = 10;
   localparam int unsigned SETTLE_CYCLES = 10;

   logic clock = 1'b0;
   logic reset;

   bdtc_req_if req_bus ();
   bdtc_rsp_if rsp_bus ();
   bdtc_csr_if csr_bus ();

   battery_discharge_test_controller dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #1 clock = ~clock;

   // -------------------------------------------------------------------------
   // Tester model: thresholds and the state carried from tick to tick
   // -------------------------------------------------------------------------
   logic [bdtc_pkg::VOLT_W-1:0] low_mv_cfg;
   logic [bdtc_pkg::OFFS_W-1:0] offset_mv_cfg;
   logic [bdtc_pkg::TICK_W-1:0] tk_count;
   logic [bdtc_pkg::SECS_W-1:0] sec_count;
   logic                        refresh_due;
   logic                        test_on;
   logic                        batt_empty;
   logic                        prev_start;
   logic [bdtc_pkg::CAP_W-1:0]  charge_uah;
   logic [bdtc_pkg::VOLT_W-1:0] volt_mv;
   logic [bdtc_pkg::CURR_W-1:0] curr_ma;

   bdtc_pkg::result_type pending_displays[$];
   int unsigned fault_count = 0;
   int unsigned quiet_cycles = 0;

   // Knobs for the traffic shape, flipped by the tests
   logic        req_gaps_on = 1'b0;
   logic        rsp_stalls_on = 1'b0;
   int unsigned rsp_stall_left = 0;
   int unsigned press_left = 0;

   // Run one tick through the model and return the status it leaves behind.
   function automatic bdtc_pkg::result_type tick_outcome(
         input logic [bdtc_pkg::VADC_W-1:0] vadc,
         input logic [bdtc_pkg::IADC_W-1:0] iadc,
         input logic start_lvl,
         input logic clear_lvl);
      logic        second_tick;
      logic        refresh;
      logic [31:0] v;
      logic [31:0] c;
      logic [bdtc_pkg::CAP_W-1:0] add;
      logic [bdtc_pkg::CAP_W:0]   sum;
      bdtc_pkg::result_type       r;

      // Timer advances only while the test runs.
      second_tick = 1'b0;
      if (test_on) begin
         tk_count = tk_count + 1'b1;
         if (tk_count >= bdtc_pkg::TICKS_PER_SECOND) begin
            tk_count = '0;
            sec_count = sec_count + 1'b1;
            second_tick = 1'b1;
         end
      end

      refresh = refresh_due || second_tick;
      refresh_due = 1'b0;

      if (refresh) begin
         v = (32'd5000 * 32'(vadc)) / 32'd1023;
         c = (32'd10000 * 32'(iadc)) / 32'd1023;
         // Wiring drop applies only above 600 mV and bottoms out at zero.
         if (v > 32'd600)
            v = (v > 32'(offset_mv_cfg)) ? v - 32'(offset_mv_cfg) : '0;
         volt_mv = v[bdtc_pkg::VOLT_W-1:0];
         curr_ma = c[bdtc_pkg::CURR_W-1:0];
         if (second_tick) begin
            add = (bdtc_pkg::CAP_W'(curr_ma) * 40'd1000) / 40'd3600;
            sum = {1'b0, charge_uah} + {1'b0, add};
            charge_uah = (sum > {1'b0, bdtc_pkg::CAP_MAX}) ? bdtc_pkg::CAP_MAX
                                                           : sum[bdtc_pkg::CAP_W-1:0];
         end
         if (volt_mv <= low_mv_cfg)
            batt_empty = 1'b1;
      end

      // Start edge toggles; an empty battery keeps forcing a stop.
      if ((!start_lvl && prev_start) || batt_empty) begin
         if (!test_on && !batt_empty) begin
            test_on = 1'b1;
         end else begin
            test_on = 1'b0;
            refresh_due = 1'b1;
         end
      end
      prev_start = start_lvl;

      if (!clear_lvl) begin
         test_on = 1'b0;
         sec_count = '0;
         tk_count = '0;
         charge_uah = '0;
         batt_empty = 1'b0;
         refresh_due = 1'b1;
      end

      r.running         = test_on;
      r.hours           = bdtc_pkg::HOUR_W'((sec_count / 3600) % 24);
      r.minutes         = bdtc_pkg::MIN_W'((sec_count / 60) % 60);
      r.seconds         = bdtc_pkg::SEC_W'(sec_count % 60);
      r.voltage_mv      = volt_mv;
      r.current_ma      = curr_ma;
      r.capacity_uah    = charge_uah;
      r.battery_empty   = batt_empty;
      r.display_refresh = refresh;
      return r;
   endfunction

   function automatic int unsigned pick_gap();
      // Mostly short gaps, now and then a long one.
      if ($urandom_range(0, 99) < 80)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic check_field(input string name, input logic [bdtc_pkg::CAP_W-1:0] want_v,
                              input logic [bdtc_pkg::CAP_W-1:0] got_v);
      if (got_v !== want_v) begin
         if (fault_count < MAX_REPORTS)
            $display("mismatch on %s: expected %0d, got %0d", name, want_v, got_v);
         fault_count++;
      end
   endtask

   // -------------------------------------------------------------------------
   // Monitor: track register writes, predict on each accepted tick and
   // compare each accepted status transaction with the oldest prediction.
   // -------------------------------------------------------------------------
   bdtc_pkg::result_type want, got;

   always @(posedge clock) begin
      if (reset) begin
         low_mv_cfg    = bdtc_pkg::LOW_VOLTAGE_RESET;
         offset_mv_cfg = bdtc_pkg::VOLTAGE_OFFSET_RESET;
         tk_count      = '0;
         sec_count     = '0;
         refresh_due   = 1'b1;
         test_on       = 1'b0;
         batt_empty    = 1'b0;
         prev_start    = 1'b1;
         charge_uah    = '0;
         volt_mv       = '0;
         curr_ma       = '0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               bdtc_pkg::CSR_LOW_VOLTAGE:
                  low_mv_cfg = csr_bus.data[bdtc_pkg::VOLT_W-1:0];
               bdtc_pkg::CSR_VOLTAGE_OFFSET:
                  offset_mv_cfg = csr_bus.data[bdtc_pkg::OFFS_W-1:0];
               default: ;
            endcase
         end
         // Predict first so a response accepted at the same edge would still find its entry.
         if (req_bus.valid && req_bus.ready)
            pending_displays.push_back(tick_outcome(req_bus.voltage_adc,
                                                    req_bus.current_adc,
                                                    req_bus.start_level,
                                                    req_bus.clear_level));
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.running         = rsp_bus.running;
            got.hours           = rsp_bus.hours;
            got.minutes         = rsp_bus.minutes;
            got.seconds         = rsp_bus.seconds;
            got.voltage_mv      = rsp_bus.voltage_mv;
            got.current_ma      = rsp_bus.current_ma;
            got.capacity_uah    = rsp_bus.capacity_uah;
            got.battery_empty   = rsp_bus.battery_empty;
            got.display_refresh = rsp_bus.display_refresh;
            if (pending_displays.size() == 0) begin
               if (fault_count < MAX_REPORTS)
                  $display("status transaction with no tick outstanding");
               fault_count++;
            end else begin
               want = pending_displays.pop_front();
               check_field("running", bdtc_pkg::CAP_W'(want.running),
                           bdtc_pkg::CAP_W'(got.running));
               check_field("hours", bdtc_pkg::CAP_W'(want.hours),
                           bdtc_pkg::CAP_W'(got.hours));
               check_field("minutes", bdtc_pkg::CAP_W'(want.minutes),
                           bdtc_pkg::CAP_W'(got.minutes));
               check_field("seconds", bdtc_pkg::CAP_W'(want.seconds),
                           bdtc_pkg::CAP_W'(got.seconds));
               check_field("voltage_mv", bdtc_pkg::CAP_W'(want.voltage_mv),
                           bdtc_pkg::CAP_W'(got.voltage_mv));
               check_field("current_ma", bdtc_pkg::CAP_W'(want.current_ma),
                           bdtc_pkg::CAP_W'(got.current_ma));
               check_field("capacity_uah", want.capacity_uah, got.capacity_uah);
               check_field("battery_empty", bdtc_pkg::CAP_W'(want.battery_empty),
                           bdtc_pkg::CAP_W'(got.battery_empty));
               check_field("display_refresh", bdtc_pkg::CAP_W'(want.display_refresh),
                           bdtc_pkg::CAP_W'(got.display_refresh));
            end
         end
      end
   end

   // Watchdog: end the run once nothing has moved on any channel for too long.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // Response side: hold ready low for random stretches when stalls are on.
   always @(negedge clock) begin
      if (!rsp_stalls_on) begin
         rsp_bus.ready = 1'b1;
      end else if (rsp_stall_left > 0) begin
         rsp_bus.ready = 1'b0;
         rsp_stall_left--;
      end else if ($urandom_range(0, 99) < 20) begin
         rsp_stall_left = pick_gap() - 1;
         rsp_bus.ready = 1'b0;
      end else begin
         rsp_bus.ready = 1'b1;
      end
   end

   // -------------------------------------------------------------------------
   // Driver tasks: called at a falling edge, they return at a falling edge.
   // -------------------------------------------------------------------------

   // Send one tick; valid stays high afterwards so back-to-back ticks stream.
   task automatic send_tick(input logic [bdtc_pkg::VADC_W-1:0] vadc,
                            input logic [bdtc_pkg::IADC_W-1:0] iadc,
                            input logic start_lvl, input logic clear_lvl);
      int unsigned gap;
      if (req_gaps_on && $urandom_range(0, 99) < 25) begin
         gap = pick_gap();
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       = 1'b1;
      req_bus.voltage_adc = vadc;
      req_bus.current_adc = iadc;
      req_bus.start_level = start_lvl;
      req_bus.clear_level = clear_lvl;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // Drop valid and hold until every predicted status has come back.
   task automatic wait_drain();
      req_bus.valid = 1'b0;
      while (pending_displays.size() != 0) @(negedge clock);
   endtask

   // Write both thresholds while the block is idle.
   task automatic write_config(input logic [bdtc_pkg::CSR_DATA_W-1:0] low_mv,
                               input logic [bdtc_pkg::CSR_DATA_W-1:0] offset_mv);
      wait_drain();
      csr_bus.valid = 1'b1;
      csr_bus.index = bdtc_pkg::CSR_LOW_VOLTAGE;
      csr_bus.data  = low_mv;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.index = bdtc_pkg::CSR_VOLTAGE_OFFSET;
      csr_bus.data  = offset_mv;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Random ticks, mostly a healthy battery under test with random load.
   // vadc_floor keeps the voltage above the empty threshold for most ticks.
   task automatic run_ticks(input int unsigned count, input int unsigned vadc_floor);
      int unsigned roll;
      logic [bdtc_pkg::VADC_W-1:0] vadc;
      logic [bdtc_pkg::IADC_W-1:0] iadc;
      logic start_lvl;
      logic clear_lvl;
      for (int unsigned n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         vadc = bdtc_pkg::VADC_W'($urandom_range(vadc_floor, 1023));
         iadc = bdtc_pkg::IADC_W'($urandom());
         clear_lvl = 1'b1;
         // Press start readily while stopped, rarely while running.
         if (press_left == 0 && ((!test_on && !batt_empty && roll < 30) || roll < 4))
            press_left = $urandom_range(1, 3);
         start_lvl = (press_left == 0);
         if (press_left > 0)
            press_left--;
         // Clear an empty battery soon, otherwise only now and then.
         if ((batt_empty && roll < 35) || roll == 99)
            clear_lvl = 1'b0;
         // Full-range voltage may run the battery down.
         if (roll >= 88 && roll < 94)
            vadc = bdtc_pkg::VADC_W'($urandom());
         // Noise: every field random.
         if (roll >= 94 && roll < 98) begin
            vadc = bdtc_pkg::VADC_W'($urandom());
            start_lvl = 1'($urandom());
            clear_lvl = ($urandom_range(0, 3) != 0);
         end
         send_tick(vadc, iadc, start_lvl, clear_lvl);
      end
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Reset leaves a refresh pending: full-scale readings show up at once.
   task automatic test_first_refresh();
      send_tick(10'd1023, 10'd1023, 1'b1, 1'b1);
      // Stopped and nothing pending: values hold.
      send_tick(10'd0, 10'd0, 1'b1, 1'b1);
   endtask

   // Start edge runs the test, a held button does nothing, a new edge stops
   // it and the stop refreshes with a low reading that marks the cell empty.
   task automatic test_start_stop();
      send_tick(10'd1000, 10'd512, 1'b0, 1'b1);
      send_tick(10'd1000, 10'd512, 1'b0, 1'b1);
      send_tick(10'd1000, 10'd512, 1'b1, 1'b1);
      send_tick(10'd1000, 10'd512, 1'b0, 1'b1);
      send_tick(10'd600, 10'd300, 1'b1, 1'b1);
   endtask

   // While empty every tick refreshes and start cannot run the test; probe
   // both sides of the 600 mV offset boundary, then clear the empty mark.
   task automatic test_empty_battery();
      send_tick(10'd1023, 10'd1023, 1'b0, 1'b1);
      send_tick(10'd122, 10'd1, 1'b1, 1'b1);
      send_tick(10'd123, 10'd1022, 1'b1, 1'b1);
      send_tick(10'd50, 10'd700, 1'b1, 1'b0);
      send_tick(10'd1023, 10'd0, 1'b1, 1'b1);
   endtask

   // Offset at and beyond its top: the reading saturates toward zero and a
   // zero threshold is met only by an exact zero.
   task automatic test_offset_saturation();
      write_config(13'd0, 13'd600);
      send_tick(10'd1023, 10'd0, 1'b1, 1'b0);
      send_tick(10'd123, 10'd345, 1'b1, 1'b1);
      send_tick(10'd123, 10'd345, 1'b1, 1'b0);
      send_tick(10'd0, 10'd678, 1'b1, 1'b1);
      write_config(13'd0, 13'd1023);
      send_tick(10'd1023, 10'd0, 1'b1, 1'b0);
      send_tick(10'd300, 10'd99, 1'b1, 1'b1);
   endtask

   // Top threshold with no offset: even full scale counts as empty.
   task automatic test_threshold_max();
      write_config(13'd5000, 13'd0);
      send_tick(10'd1023, 10'd1023, 1'b1, 1'b0);
      send_tick(10'd1023, 10'd1023, 1'b0, 1'b1);
      send_tick(10'd1023, 10'd1023, 1'b1, 1'b0);
   endtask

   // Default-like thresholds with gaps and stalls on both sides.
   task automatic test_random_nominal();
      write_config(13'd3000, 13'd200);
      req_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
      run_ticks(150, 800);
   endtask

   // Zero thresholds, no idling; halfway the sender holds until drained.
   task automatic test_random_hold_until_drained();
      write_config(13'd0, 13'd0);
      req_gaps_on = 1'b0;
      rsp_stalls_on = 1'b0;
      run_ticks(75, 0);
      wait_drain();
      run_ticks(75, 0);
   endtask

   // High threshold with full offset: the cell hovers near empty.
   task automatic test_random_near_empty();
      write_config(13'd4200, 13'd600);
      req_gaps_on = 1'b1;
      rsp_stalls_on = 1'b0;
      run_ticks(120, 980);
   endtask

   // Threshold at the full-scale 5000 mV: every refresh marks empty.
   task automatic test_random_always_empty();
      write_config(13'd5000, 13'd1023);
      req_gaps_on = 1'b0;
      rsp_stalls_on = 1'b1;
      run_ticks(50, 0);
   endtask

   // Mid thresholds, both sides idling again.
   task automatic test_random_mixed();
      write_config(13'd1000, 13'd600);
      req_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
      run_ticks(80, 400);
   endtask

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin
      reset = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.voltage_adc = '0;
      req_bus.current_adc = '0;
      req_bus.start_level = 1'b1;
      req_bus.clear_level = 1'b1;
      rsp_bus.ready       = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = bdtc_pkg::CSR_LOW_VOLTAGE;
      csr_bus.data        = '0;

      // Hold reset, then release it on a falling edge.
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      rsp_stalls_on = 1'b1;
      test_first_refresh();
      test_start_stop();
      test_empty_battery();
      test_offset_saturation();
      test_threshold_max();

      test_random_nominal();
      test_random_hold_until_drained();
      test_random_near_empty();
      test_random_always_empty();
      test_random_mixed();

      // Drain, let the pipeline settle, then account for anything left over.
      wait_drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      fault_count += pending_displays.size();

      if (fault_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

/* sim.f */
+incdir+src
src/bdtc_pkg.sv
src/bdtc_req_if.sv
src/bdtc_rsp_if.sv
src/bdtc_csr_if.sv
src/bdtc_convert.sv
src/bdtc_charge.sv
src/bdtc_state.sv
src/battery_discharge_test_controller.sv
tb/tb.sv
